### hdl/nab_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Neighbour average blur package
// Item types, register codes and fixed widths shared by the blur unit files.
// ----------------------------------------------------------------------------
package nab_pkg;

  localparam int PIX_W = 16;
  localparam int CFG_W = 11;
  localparam int SUM_W = PIX_W + 3;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd800;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd600;

  localparam logic REQ_DRAIN = 1'b1;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic             req_type;
    logic [PIX_W-1:0] pixel_in;
  } nab_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             frame_done;
  } nab_out_t;

endpackage

### hdl/nab_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Simple dual-port RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module nab_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1026
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hdl/inplace_neighbour_average_blur_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// In-place neighbour average blur unit
// Column-major pixel stream; interior pixels become the mean of their eight
// neighbours, with the left column and the pixel above taken after filtering.
// ----------------------------------------------------------------------------
// Throughput: one item per clock unless the output stalls. An item that causes
// a result has it in the working stage register, then the output register;
// results trail their pixels by frame_height + 1 items, flushed at the end
// by drain items. The limit is the single registered read of each RAM per item.
// Reset (synchronous): counters, pointers and valids clear, the size registers
// return to 800 x 600; the delay RAMs are not cleared and need no sweep.
module inplace_neighbour_average_blur_unit #(
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_WIDTH  = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  nab_pkg::nab_in_t in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output nab_pkg::nab_out_t out_item,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  import nab_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int DEPTH = MAX_HEIGHT + 2;
  localparam int AW    = $clog2(DEPTH);

  // Configuration registers and their clamped values.
  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;
  logic [WW-1:0]    eff_w;
  logic [HW-1:0]    eff_h;
  logic             cfg_write;

  // Frame position counters, kept at the input side.
  logic [CW-1:0] in_col, in_col_next;
  logic [RW-1:0] in_row, in_row_next;
  logic [CW-1:0] out_col, out_col_next;
  logic [RW-1:0] out_row, out_row_next;
  logic          out_started, out_started_next;
  logic          in_done, in_done_next;

  logic             drain, step, emit, interior, last;
  logic [PIX_W-1:0] pix_step;
  logic [WW-1:0]    col_inc, ocol_inc;
  logic [HW-1:0]    row_inc, orow_inc;
  logic [WW:0]      x_plus2;
  logic [HW:0]      y_plus2;
  logic             in_fire;

  // Delay store pointers.
  logic [AW-1:0] orig_wr, orig_wr_inc, orig_rd_addr;
  logic [AW-1:0] res_issue, res_issue_inc, res_rd_addr;
  logic [AW-1:0] res_wr, res_wr_inc;
  logic [AW:0]   orig_diff, res_diff;

  // Working stage.
  logic             s1_valid, s1_emit, s1_interior, s1_last;
  logic [PIX_W-1:0] s1_pix;
  logic             s1_go;
  logic [PIX_W-1:0] orig_tap_h, orig_tap_h1, orig_tap_1, orig_tap_2;
  logic [PIX_W-1:0] res_tap_hm1, res_tap_h, res_tap_h1, res_prev;
  logic [SUM_W-1:0] sum;
  logic [PIX_W-1:0] result;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;

  always_comb begin
    unique case (reg_index_t'(paddr[2]))
      REG_FRAME_WIDTH:  prdata = {{(32-CFG_W){1'b0}}, frame_width};
      REG_FRAME_HEIGHT: prdata = {{(32-CFG_W){1'b0}}, frame_height};
    endcase
  end

  always_comb begin
    if (frame_width < 11'd4) begin
      eff_w = WW'(4);
    end else if (int'(frame_width) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(frame_width);
    end
    if (frame_height < 11'd4) begin
      eff_h = HW'(4);
    end else if (int'(frame_height) > MAX_HEIGHT) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = HW'(frame_height);
    end
  end

  // --------------------------------------------------------------------------
  // Input side: frame bookkeeping for the item on offer
  // --------------------------------------------------------------------------
  always_comb begin
    drain = (in_item.req_type == REQ_DRAIN) | in_done;
    // A drain item while the frame is still arriving is swallowed.
    step     = !((in_item.req_type == REQ_DRAIN) && !in_done);
    pix_step = drain ? '0 : in_item.pixel_in;

    in_col_next      = in_col;
    in_row_next      = in_row;
    out_col_next     = out_col;
    out_row_next     = out_row;
    out_started_next = out_started;
    in_done_next     = in_done;
    emit             = 1'b0;
    interior         = 1'b0;
    last             = 1'b0;

    col_inc  = WW'(in_col) + WW'(1);
    row_inc  = HW'(in_row) + HW'(1);
    ocol_inc = WW'(out_col) + WW'(1);
    orow_inc = HW'(out_row) + HW'(1);
    x_plus2  = (WW+1)'(out_col) + (WW+1)'(2);
    y_plus2  = (HW+1)'(out_row) + (HW+1)'(2);

    if (!drain) begin
      if (row_inc >= eff_h) begin
        in_row_next = '0;
        if (col_inc >= eff_w) begin
          in_col_next  = '0;
          in_done_next = 1'b1;
        end else begin
          in_col_next = col_inc[CW-1:0];
        end
      end else begin
        in_row_next = row_inc[RW-1:0];
      end
    end

    if (!out_started) begin
      // Output begins once the pixel below-right of the first one has entered.
      if (in_done_next || (in_col_next > CW'(1)) ||
          ((in_col_next == CW'(1)) && (in_row_next != '0))) begin
        out_started_next = 1'b1;
      end
    end else begin
      emit     = 1'b1;
      interior = (out_col >= CW'(2)) && (x_plus2 <= {1'b0, eff_w}) &&
                 (out_row >= RW'(2)) && (y_plus2 <= {1'b0, eff_h});
      if (orow_inc >= eff_h) begin
        out_row_next = '0;
        if (ocol_inc >= eff_w) begin
          last = 1'b1;
        end else begin
          out_col_next = ocol_inc[CW-1:0];
        end
      end else begin
        out_row_next = orow_inc[RW-1:0];
      end
      if (last) begin
        in_col_next      = '0;
        in_row_next      = '0;
        out_col_next     = '0;
        out_row_next     = '0;
        out_started_next = 1'b0;
        in_done_next     = 1'b0;
      end
    end
  end

  assign in_ready = !s1_valid || s1_go;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
      in_col       <= '0;
      in_row       <= '0;
      out_col      <= '0;
      out_row      <= '0;
      out_started  <= 1'b0;
      in_done      <= 1'b0;
    end else if (cfg_write) begin
      unique case (reg_index_t'(paddr[2]))
        REG_FRAME_WIDTH:  frame_width  <= pwdata[CFG_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= pwdata[CFG_W-1:0];
      endcase
      in_col      <= '0;
      in_row      <= '0;
      out_col     <= '0;
      out_row     <= '0;
      out_started <= 1'b0;
      in_done     <= 1'b0;
    end else if (in_fire && step) begin
      in_col      <= in_col_next;
      in_row      <= in_row_next;
      out_col     <= out_col_next;
      out_row     <= out_row_next;
      out_started <= out_started_next;
      in_done     <= in_done_next;
    end
  end

  // --------------------------------------------------------------------------
  // Delay store addressing (circular, depth MAX_HEIGHT + 2)
  // --------------------------------------------------------------------------
  assign orig_wr_inc   = (orig_wr == AW'(DEPTH - 1)) ? '0 : orig_wr + AW'(1);
  assign res_issue_inc = (res_issue == AW'(DEPTH - 1)) ? '0 : res_issue + AW'(1);
  assign res_wr_inc    = (res_wr == AW'(DEPTH - 1)) ? '0 : res_wr + AW'(1);

  // The original taken height items back is the pixel below; the result taken
  // height minus one back is the filtered pixel down-left.
  assign orig_diff    = {1'b0, orig_wr} - (AW+1)'(eff_h);
  assign orig_rd_addr = orig_diff[AW] ? AW'(orig_diff + (AW+1)'(DEPTH)) : AW'(orig_diff);
  assign res_diff     = {1'b0, res_issue} - (AW+1)'(eff_h) + (AW+1)'(1);
  assign res_rd_addr  = res_diff[AW] ? AW'(res_diff + (AW+1)'(DEPTH)) : AW'(res_diff);

  always_ff @(posedge clk) begin
    if (rst) begin
      orig_wr   <= '0;
      res_issue <= '0;
      res_wr    <= '0;
    end else begin
      if (in_fire && step) begin
        orig_wr <= orig_wr_inc;
        if (emit) begin
          res_issue <= res_issue_inc;
        end
      end
      if (s1_go && s1_emit) begin
        res_wr <= res_wr_inc;
      end
    end
  end

  nab_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_orig_ram (
    .clk     (clk),
    .wr_en   (in_fire && step),
    .wr_addr (orig_wr),
    .wr_data (pix_step),
    .rd_en   (in_fire && step),
    .rd_addr (orig_rd_addr),
    .rd_data (orig_tap_h)
  );

  nab_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_res_ram (
    .clk     (clk),
    .wr_en   (s1_go && s1_emit),
    .wr_addr (res_wr),
    .wr_data (result),
    .rd_en   (in_fire && step && emit),
    .rd_addr (res_rd_addr),
    .rd_data (res_tap_hm1)
  );

  // --------------------------------------------------------------------------
  // Working stage: eight-neighbour sum
  // --------------------------------------------------------------------------
  assign s1_go = s1_valid && (!s1_emit || !out_valid || out_ready);

  assign sum = SUM_W'(res_tap_h1) + SUM_W'(res_tap_h) + SUM_W'(res_tap_hm1) +
               SUM_W'(res_prev) + SUM_W'(orig_tap_h) + SUM_W'(orig_tap_2) +
               SUM_W'(orig_tap_1) + SUM_W'(s1_pix);
  assign result = s1_interior ? sum[SUM_W-1:3] : orig_tap_h1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid && step;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && step) begin
      s1_emit     <= emit;
      s1_interior <= interior;
      s1_last     <= last;
      s1_pix      <= pix_step;
    end
    if (s1_go) begin
      orig_tap_h1 <= orig_tap_h;
      orig_tap_2  <= orig_tap_1;
      orig_tap_1  <= s1_pix;
      if (s1_emit) begin
        res_tap_h1 <= res_tap_h;
        res_tap_h  <= res_tap_hm1;
        res_prev   <= result;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_emit) begin
      out_item.pixel_out  <= result;
      out_item.frame_done <= s1_last;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // The result store is written exactly one item behind the read issue point
  // while a result sits in the working stage, and level with it otherwise.
  assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_emit) |-> (res_issue == res_wr_inc))
    else $error("result issue pointer not one ahead of write pointer");

  assert property (@(posedge clk) disable iff (rst)
    !(s1_valid && s1_emit) |-> (res_issue == res_wr))
    else $error("result issue and write pointers out of step");

  // Once the whole frame has entered, output must already be running.
  assert property (@(posedge clk) disable iff (rst)
    in_done |-> out_started)
    else $error("frame complete at input but output never started");

endmodule
